FILE: rtl/core/spim_pkg.sv
// shared types, constants and codes for the servo pulse i2c write master
`timescale 1ns / 1ps

package spim_pkg;

  // number of servo outputs on the pwm chip
  localparam int unsigned CHANNELS = 16;

  // register reset values
  localparam logic [7:0]  RST_BUS_ADDR  = 8'h80;
  localparam logic [7:0]  RST_PRESCALE  = 8'd121;
  localparam logic [15:0] RST_STEP      = 16'd30;
  localparam logic [19:0] RST_WAKE_WAIT = 20'd10000;

  // pwm chip register map and mode values
  localparam logic [7:0] REG_MODE     = 8'h00;
  localparam logic [7:0] REG_PRESCALE = 8'hFE;
  localparam logic [7:0] REG_LED0     = 8'h06;
  localparam logic [7:0] MODE_SLEEP   = 8'h11;
  localparam logic [7:0] MODE_RESTART = 8'hA1;
  localparam logic [7:0] MODE_RUN     = 8'h21;

  // angle to off count: off = OFF_BASE + floor(a * 410 / 2880)
  // floor(a * 41 / 288) == (a * OFF_RECIP) >> OFF_SHIFT, exact for a < 6553
  localparam logic [11:0] ANGLE_MAX = 12'd2880;
  localparam logic [9:0]  OFF_BASE  = 10'd102;
  localparam logic [17:0] OFF_RECIP = 18'd149277;
  localparam int unsigned OFF_SHIFT = 20;

  // register indexes on the config port
  typedef enum logic [1:0] {
    RIDX_BUS_ADDR  = 2'd0,
    RIDX_PRESCALE  = 2'd1,
    RIDX_STEP      = 2'd2,
    RIDX_WAKE_WAIT = 2'd3
  } reg_idx_t;

  // input selector
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ANGLE = 2'd1,
    FUNC_INIT  = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  // classified item kind
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ANGLE  = 2'd1,
    KIND_INIT   = 2'd2,
    KIND_BAD_CH = 2'd3
  } kind_t;

  // result status
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_BAD_CH   = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST0  = 4'd1,
    PH_ST1  = 4'd2,
    PH_ST2  = 4'd3,
    PH_ST3  = 4'd4,
    PH_BD   = 4'd5,
    PH_BH   = 4'd6,
    PH_BL   = 4'd7,
    PH_SP0  = 4'd8,
    PH_SP1  = 4'd9,
    PH_SP2  = 4'd10,
    PH_WAIT = 4'd11
  } phase_t;

  // write stages of a sequence
  typedef enum logic [2:0] {
    STG_SLEEP   = 3'd0,
    STG_PRESC   = 3'd1,
    STG_RESTART = 3'd2,
    STG_SPARE   = 3'd3,
    STG_RUN     = 3'd4,
    STG_FRAME   = 3'd5
  } stage_t;

  // live configuration
  typedef struct packed {
    logic [7:0]  bus_addr;
    logic [7:0]  prescale;
    logic [15:0] step_ticks;
    logic [19:0] wake_wait;
  } cfg_t;

  // classified item held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] reg_byte;
    logic [9:0] off;
  } item_t;

endpackage

FILE: rtl/core/spim_regs.sv
// apb-style configuration registers
`timescale 1ns / 1ps

module spim_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output spim_pkg::cfg_t     cfg
);
  import spim_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_addr   <= RST_BUS_ADDR;
      cfg_r.prescale   <= RST_PRESCALE;
      cfg_r.step_ticks <= RST_STEP;
      cfg_r.wake_wait  <= RST_WAKE_WAIT;
    end else if (wr) begin
      unique case (idx)
        RIDX_BUS_ADDR:  cfg_r.bus_addr   <= pwdata[7:0];
        RIDX_PRESCALE:  cfg_r.prescale   <= pwdata[7:0];
        RIDX_STEP:      cfg_r.step_ticks <= pwdata[15:0];
        RIDX_WAKE_WAIT: cfg_r.wake_wait  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RIDX_BUS_ADDR:  prdata = {24'd0, cfg_r.bus_addr};
      RIDX_PRESCALE:  prdata = {24'd0, cfg_r.prescale};
      RIDX_STEP:      prdata = {16'd0, cfg_r.step_ticks};
      RIDX_WAKE_WAIT: prdata = {12'd0, cfg_r.wake_wait};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/spim_front.sv
// front end: classifies input beats and computes the pwm off count
`timescale 1ns / 1ps

module spim_front (
  input  logic [1:0]          func_in,
  input  logic [7:0]          channel,
  input  logic signed [12:0]  angle_q4,
  output spim_pkg::item_t     item
);
  import spim_pkg::*;

  func_t       fsel;
  logic [11:0] ang;
  logic [29:0] prod;
  logic        bad_ch;

  assign fsel   = func_t'(func_in);
  assign bad_ch = (channel >= 8'(CHANNELS));

  // clamp to 0..2880, negative reads as zero
  always_comb begin
    if (angle_q4[12]) begin
      ang = 12'd0;
    end else if (angle_q4[11:0] > ANGLE_MAX) begin
      ang = ANGLE_MAX;
    end else begin
      ang = angle_q4[11:0];
    end
  end

  assign prod = 30'(ang) * 30'(OFF_RECIP);

  always_comb begin
    item.off      = OFF_BASE + 10'(prod[29:OFF_SHIFT]);
    item.reg_byte = REG_LED0 + {channel[5:0], 2'b00};
    unique case (fsel)
      FUNC_ANGLE: item.kind = bad_ch ? KIND_BAD_CH : KIND_ANGLE;
      FUNC_INIT:  item.kind = KIND_INIT;
      default:    item.kind = KIND_TICK;
    endcase
  end

endmodule

FILE: rtl/core/spim_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps

module spim_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spim_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output spim_pkg::item_t  q_item
);
  import spim_pkg::*;

  item_t      mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt  = do_push ? ~wptr_r : wptr_r;
    rptr_nxt  = do_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/spim_back.sv
// back end: bus sequencer stepped once per item, plus output register
`timescale 1ns / 1ps

module spim_back (
  input  logic             clk,
  input  logic             rst_n,
  input  spim_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  spim_pkg::item_t  q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_scl,
  output logic             out_sda,
  output logic             out_busy,
  output logic [1:0]       out_status
);
  import spim_pkg::*;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic        pend_r, pend_nxt;
  logic        init_r, init_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  // latched frame
  logic [7:0]  faddr_r, faddr_nxt;
  logic [7:0]  freg_r, freg_nxt;
  logic [9:0]  foff_r, foff_nxt;

  // output register
  logic        ov_r;
  logic        oscl_r, osda_r, obusy_r;
  status_t     ostat_r;

  // scratch
  logic        was_busy;
  logic        start_go;
  stage_t      start_stg;
  logic        enter_go;
  phase_t      enter_ph;
  logic [15:0] tick_dec;
  logic [19:0] wait_dec;
  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;
  logic [2:0]  len;
  status_t     status;

  function automatic logic [7:0] stage_byte(stage_t s, logic [2:0] i, cfg_t c,
                                            logic [7:0] fa, logic [7:0] fr,
                                            logic [9:0] fo);
    logic [7:0] b;
    b = 8'd0;
    if (s == STG_FRAME) begin
      unique case (i)
        3'd0:    b = fa;
        3'd1:    b = fr;
        3'd4:    b = fo[7:0];
        3'd5:    b = {6'd0, fo[9:8]};
        default: b = 8'd0;
      endcase
    end else if (i == 3'd0) begin
      b = c.bus_addr;
    end else if (i == 3'd1) begin
      b = (s == STG_PRESC) ? REG_PRESCALE : REG_MODE;
    end else begin
      unique case (s)
        STG_SLEEP:   b = MODE_SLEEP;
        STG_PRESC:   b = c.prescale;
        STG_RESTART: b = MODE_RESTART;
        default:     b = MODE_RUN;
      endcase
    end
    return b;
  endfunction

  assign pop = q_valid && (!ov_r || out_ready);

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    wait_nxt  = wait_r;
    pend_nxt  = pend_r;
    init_nxt  = init_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    faddr_nxt = faddr_r;
    freg_nxt  = freg_r;
    foff_nxt  = foff_r;
    start_go  = 1'b0;
    start_stg = STG_SLEEP;
    enter_go  = 1'b0;
    enter_ph  = PH_IDLE;
    status    = ST_NONE;
    len       = (stage_r == STG_FRAME) ? 3'd6 : 3'd3;
    bit_inc   = bit_r + 4'd1;
    byte_inc  = byte_r + 3'd1;
    tick_dec  = (tick_r != 16'd0) ? tick_r - 16'd1 : 16'd0;
    wait_dec  = (wait_r != 20'd0) ? wait_r - 20'd1 : 20'd0;
    was_busy  = (phase_r != PH_IDLE);

    // running sequence advances one tick
    if (was_busy) begin
      if (phase_r == PH_WAIT) begin
        wait_nxt = wait_dec;
        if (wait_dec == 20'd0) begin
          start_go  = 1'b1;
          start_stg = STG_RUN;
        end
      end else begin
        tick_nxt = tick_dec;
        if (tick_dec == 16'd0) begin
          unique case (phase_r)
            PH_ST0: begin enter_go = 1'b1; enter_ph = PH_ST1; end
            PH_ST1: begin enter_go = 1'b1; enter_ph = PH_ST2; end
            PH_ST2: begin enter_go = 1'b1; enter_ph = PH_ST3; end
            PH_ST3: begin enter_go = 1'b1; enter_ph = PH_BD;  end
            PH_BD:  begin enter_go = 1'b1; enter_ph = PH_BH;  end
            PH_BH:  begin enter_go = 1'b1; enter_ph = PH_BL;  end
            PH_SP0: begin enter_go = 1'b1; enter_ph = PH_SP1; end
            PH_SP1: begin enter_go = 1'b1; enter_ph = PH_SP2; end
            PH_BL: begin
              bit_nxt   = bit_inc;
              shift_nxt = {shift_r[6:0], 1'b0};
              enter_go  = 1'b1;
              enter_ph  = PH_BD;
              // the ack clock follows the eight data bits, then next byte or stop
              if (bit_inc >= 4'd9) begin
                byte_nxt = byte_inc;
                if (byte_inc >= len) begin
                  enter_ph = PH_SP0;
                end else begin
                  bit_nxt   = 4'd0;
                  shift_nxt = stage_byte(stage_r, byte_inc, cfg, faddr_r, freg_r, foff_r);
                end
              end
            end
            PH_SP2: begin
              priority if (stage_r == STG_RESTART) begin
                if (cfg.wake_wait != 20'd0) begin
                  wait_nxt  = cfg.wake_wait;
                  phase_nxt = PH_WAIT;
                end else begin
                  start_go  = 1'b1;
                  start_stg = STG_RUN;
                end
              end else if (stage_r == STG_SLEEP) begin
                start_go  = 1'b1;
                start_stg = STG_PRESC;
              end else if (stage_r == STG_PRESC) begin
                start_go  = 1'b1;
                start_stg = STG_RESTART;
              end else if (stage_r == STG_RUN && pend_r) begin
                pend_nxt  = 1'b0;
                start_go  = 1'b1;
                start_stg = STG_FRAME;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
    end

    // commands, judged on the busy state at the start of the item
    unique case (q_item.kind)
      KIND_BAD_CH: status = ST_BAD_CH;
      KIND_ANGLE: begin
        if (was_busy) begin
          status = ST_BUSY;
        end else begin
          status    = ST_ACCEPTED;
          faddr_nxt = cfg.bus_addr;
          freg_nxt  = q_item.reg_byte;
          foff_nxt  = q_item.off;
          start_go  = 1'b1;
          if (!init_r) begin
            init_nxt  = 1'b1;
            pend_nxt  = 1'b1;
            start_stg = STG_SLEEP;
          end else begin
            start_stg = STG_FRAME;
          end
        end
      end
      KIND_INIT: begin
        if (was_busy) begin
          status = ST_BUSY;
        end else begin
          status = ST_ACCEPTED;
          if (!init_r) begin
            init_nxt  = 1'b1;
            pend_nxt  = 1'b0;
            start_go  = 1'b1;
            start_stg = STG_SLEEP;
          end
        end
      end
      default: ;
    endcase

    // open a new write: start condition, first byte loaded
    if (start_go) begin
      stage_nxt = start_stg;
      byte_nxt  = 3'd0;
      bit_nxt   = 4'd0;
      shift_nxt = stage_byte(start_stg, 3'd0, cfg, faddr_nxt, freg_nxt, foff_nxt);
      enter_go  = 1'b1;
      enter_ph  = PH_ST0;
    end

    // apply the pin step of the phase entered and reload the step timer
    if (enter_go) begin
      phase_nxt = enter_ph;
      tick_nxt  = (cfg.step_ticks == 16'd0) ? 16'd1 : cfg.step_ticks;
      unique case (enter_ph)
        PH_ST0:  sda_nxt = 1'b1;
        PH_ST1:  scl_nxt = 1'b1;
        PH_ST2:  sda_nxt = 1'b0;
        PH_ST3:  scl_nxt = 1'b0;
        PH_BD:   sda_nxt = (bit_nxt >= 4'd8) ? 1'b1 : shift_nxt[7];
        PH_BH:   scl_nxt = 1'b1;
        PH_BL:   scl_nxt = 1'b0;
        PH_SP0:  sda_nxt = 1'b0;
        PH_SP1:  scl_nxt = 1'b1;
        PH_SP2:  sda_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stage_r <= STG_SLEEP;
      bit_r   <= 4'd0;
      byte_r  <= 3'd0;
      shift_r <= 8'd0;
      tick_r  <= 16'd0;
      wait_r  <= 20'd0;
      pend_r  <= 1'b0;
      init_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        stage_r <= stage_nxt;
        bit_r   <= bit_nxt;
        byte_r  <= byte_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        wait_r  <= wait_nxt;
        pend_r  <= pend_nxt;
        init_r  <= init_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ov_r    <= 1'b1;
      end else if (out_ready) begin
        ov_r    <= 1'b0;
      end
    end
  end

  // frame bytes and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      faddr_r <= faddr_nxt;
      freg_r  <= freg_nxt;
      foff_r  <= foff_nxt;
      oscl_r  <= scl_nxt;
      osda_r  <= sda_nxt;
      obusy_r <= (phase_nxt != PH_IDLE);
      ostat_r <= status;
    end
  end

  assign out_valid  = ov_r;
  assign out_scl    = oscl_r;
  assign out_sda    = osda_r;
  assign out_busy   = obusy_r;
  assign out_status = ostat_r;

endmodule

FILE: rtl/core/servo_pulse_i2c_write_master.sv
// top level of the servo pulse i2c write master
`timescale 1ns / 1ps

// Write-only two-wire bus master for a 16-channel servo pwm chip. Every input
// beat is one clock of bus time: a tick beat only advances the running bus
// sequence, an init beat or the first angle beat sends the wake-up writes
// (mode sleep, prescale, mode restart, a wait of wake_wait_ticks, mode run),
// and an angle beat taken while idle sends one six-byte frame with on = 0 and
// off = 102 + angle * 410 / 180. Each pin step is held step_ticks beats and
// ack clocks are sent with sda released and not sampled. Every input beat
// gives exactly one result beat with the line levels after that beat, the
// busy flag and a status code. The block takes one beat per clock while the
// queue has room: the front classifies a beat and works out the off count
// with one constant multiply, a two-entry queue holds classified beats, and
// the back steps the bus sequencer once per beat into an output register. An
// input beat is registered in the queue and then in the output register
// before its result beat is presented, and a stalled result side stops input
// only once the queue holds two beats. Config registers sit at byte addresses
// 0x0 bus_address, 0x4 prescale_value, 0x8 step_ticks, 0xc wake_wait_ticks;
// write them only while no beats are in flight.

module servo_pulse_i2c_write_master (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] channel, [20:8] angle_q4, [23:21] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] scl, [1] sda, [2] busy_res, [4:3] status, [7:5] zero
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import spim_pkg::*;

  cfg_t       cfg;
  item_t      fr_item;
  item_t      q_item;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       o_scl, o_sda, o_busy;
  logic [1:0] o_status;

  // pready tied high, writes land in the access cycle
  assign cfg_pready = 1'b1;

  spim_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // classify beat, clamp angle, off count
  spim_front u_front (
    .func_in  (in_tuser),
    .channel  (in_tdata[7:0]),
    .angle_q4 (in_tdata[20:8]),
    .item     (fr_item)
  );

  assign in_tready = !q_full;

  spim_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // bus sequencer and result register
  spim_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_scl    (o_scl),
    .out_sda    (o_sda),
    .out_busy   (o_busy),
    .out_status (o_status)
  );

  assign out_tdata = {3'd0, o_status, o_busy, o_sda, o_scl};

endmodule

FILE: rtl/core/spim_checker.sv
// port-level checker for the servo pulse i2c write master, with its bind
`timescale 1ns / 1ps

module spim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // a draining result side never holds off input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |=> in_tready)
    else $error("input stalled while results drain");

  // idle bus is released on both lines
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("bus lines driven while idle");

endmodule

bind servo_pulse_i2c_write_master spim_checker u_spim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
